[hw/rtl/ddfc_pkg.sv]
// Package: shared constants and types of the disk DMA double buffer controller.
package ddfc_pkg;
   localparam int BufferBytes = 16;
   localparam int SectorBytes = 512;
   localparam int StoreSize = 2 * BufferBytes;
   localparam int IdxW = $clog2(BufferBytes);
   localparam int SlotW = $clog2(StoreSize);
   localparam int PendW = $clog2(StoreSize + 1);
   localparam int FillW = $clog2(BufferBytes + 1);
   localparam int SecW = $clog2(SectorBytes + 1);

   localparam logic [2:0] MODE_WRITE = 3'd0;
   localparam logic [2:0] MODE_READ = 3'd1;
   localparam logic [2:0] MODE_DEVREQ = 3'd2;
   localparam logic [2:0] MODE_RELEASE = 3'd3;
   localparam logic [2:0] MODE_REPLY = 3'd4;

   localparam logic [2:0] SEL_CTRL = 3'd0;
   localparam logic [2:0] SEL_SECT = 3'd1;
   localparam logic [2:0] SEL_ADDRH = 3'd2;
   localparam logic [2:0] SEL_ADDRM = 3'd3;
   localparam logic [2:0] SEL_ADDRL = 3'd4;

   localparam logic [1:0] KIND_REGRD = 2'd0;
   localparam logic [1:0] KIND_MEMWR = 2'd1;
   localparam logic [1:0] KIND_MEMRD = 2'd2;
   localparam logic [1:0] KIND_DEV = 2'd3;

   localparam logic [15:0] CTRL_FLOPPY = 16'h0080;
   localparam logic [15:0] CTRL_DIR = 16'h0100;
   localparam logic [15:0] CTRL_SECT = 16'h0010;

   typedef struct packed {
      logic [1:0] kind;
      logic [15:0] read_data;
      logic [23:0] mem_address;
      logic [7:0] mem_data;
      logic [7:0] device_data;
      logic to_floppy;
      logic last;
   } rsp_type;
endpackage

[hw/rtl/ddfc_buffer_ram.sv]
// Buffer RAM: two byte buffers in one synchronous memory with registered read.
module ddfc_buffer_ram (
   input logic clock,
   input logic wr_en,
   input logic [ddfc_pkg::SlotW-1:0] wr_addr,
   input logic [7:0] wr_data,
   input logic [ddfc_pkg::SlotW-1:0] rd_addr,
   output logic [7:0] rd_data
);
   import ddfc_pkg::*;
   logic [7:0] mem [StoreSize];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

[hw/rtl/disk_dma_double_fifo_controller.sv]
// Top level: disk DMA controller with two alternating byte buffers.
// Results: a register read answers from the execute state; a device byte waits for the
// RAM read in the device state; a memory write burst first primes the read of its first byte.
// One transaction at a time: a new request is taken only while idle with the output empty;
// bursts carry 16 or 32 results.
// Reset (synchronous, active high) clears all control state; buffer bytes stay unknown.
module disk_dma_double_fifo_controller (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   // tdata: mode[2:0], reg_select[5:3], write_data[21:6], device_byte[29:22],
   // memory_byte[37:30], zero fill [39:38]
   input logic [39:0] req_tdata,
   output logic rsp_tvalid,
   input logic rsp_tready,
   // tdata: read_data[15:0], mem_address[39:16], mem_data[47:40], device_data[55:48],
   // to_floppy[56], zero fill [63:57]
   output logic [63:0] rsp_tdata,
   output logic [1:0] rsp_tuser, // kind[1:0]
   output logic rsp_tlast
);
   import ddfc_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_BURST = 3'd2;
   localparam logic [2:0] ST_DEV = 3'd3;

   logic [2:0] state_ff, state_in;
   logic [2:0] mode_ff, sel_ff;
   logic [15:0] wd_ff;
   logic [7:0] dbyte_ff, mbyte_ff;

   logic [15:0] ctrl_ff;
   logic [2:0] status_ff;
   logic [23:0] addr_ff;
   logic [15:0] sect_ff;
   logic [SecW-1:0] bis_ff;
   logic act_ff;
   logic [FillW-1:0] fill_ff [2];
   logic [FillW-1:0] ridx_ff [2];
   logic [SlotW-1:0] slot_ff;
   logic [PendW-1:0] pend_ff;

   // burst sequencer
   logic [PendW-1:0] bcnt_ff;   // transactions left
   logic bwrite_ff;             // memory write burst (else read requests)
   logic bbase_ff;              // buffer being flushed
   logic [IdxW-1:0] bpos_ff;
   logic bfirst_ff;             // RAM read for first byte issued

   rsp_type out_ff, out_in;
   logic out_v_ff;
   logic out_set;

   logic ram_we;
   logic [SlotW-1:0] ram_wa, ram_ra;
   logic [7:0] ram_wd, ram_rd;

   ddfc_buffer_ram u_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   assign req_tready = (state_ff == ST_IDLE) && !out_v_ff;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser = out_ff.kind;
   assign rsp_tlast = out_ff.last;
   assign rsp_tdata = {7'd0, out_ff.to_floppy, out_ff.device_data, out_ff.mem_data,
                       out_ff.mem_address, out_ff.read_data};

   logic out_free;
   assign out_free = !out_v_ff || rsp_tready;

   logic dir;
   assign dir = |(ctrl_ff & CTRL_DIR);
   logic [IdxW-1:0] rpos;
   assign rpos = ridx_ff[act_ff][IdxW-1:0];
   logic [IdxW-1:0] wpos;
   assign wpos = fill_ff[act_ff][IdxW-1:0];

   // RAM ports: write for device stores and memory replies, read for device
   // output and flush bursts
   always_comb begin
      ram_we = 1'b0;
      ram_wa = {act_ff, wpos};
      ram_wd = dbyte_ff;
      ram_ra = {act_ff, rpos};
      if (state_ff == ST_EXEC && mode_ff == MODE_DEVREQ && sect_ff != 16'd0 && !dir)
         ram_we = 1'b1;
      if (state_ff == ST_EXEC && mode_ff == MODE_REPLY && pend_ff != '0) begin
         ram_we = 1'b1;
         ram_wa = slot_ff;
         ram_wd = mbyte_ff;
      end
      // while the output stalls, re-read the byte on hold so the RAM data stays aligned
      if (state_ff == ST_BURST) begin
         if (bfirst_ff && !out_free) ram_ra = {bbase_ff, bpos_ff - IdxW'(1)};
         else ram_ra = {bbase_ff, bpos_ff};
      end
   end

   rsp_type blank;
   always_comb begin
      blank = '0;
      blank.to_floppy = |(ctrl_ff & CTRL_FLOPPY);
   end

   // sector counter step: returns updated values; flag when transfer ends
   logic [SecW-1:0] bis_step;
   logic [15:0] sect_step;
   logic sect_end;
   always_comb begin
      bis_step = bis_ff + SecW'(1);
      sect_step = sect_ff;
      sect_end = 1'b0;
      if (bis_step >= SecW'(SectorBytes)) begin
         bis_step = '0;
         sect_step = sect_ff - 16'd1;
         sect_end = (sect_step == 16'd0);
      end
   end

   // state after the execute cycle
   always_comb begin
      state_in = ST_IDLE;
      case (mode_ff)
         MODE_WRITE: begin
            if (sel_ff == SEL_SECT && |(ctrl_ff & CTRL_SECT) && dir) state_in = ST_BURST;
         end
         MODE_DEVREQ: begin
            if (sect_ff != 16'd0) begin
               if (dir) state_in = ST_DEV;
               else if (FillW'(wpos) + FillW'(1) >= FillW'(BufferBytes))
                  state_in = ST_BURST;
            end
         end
         default: ;
      endcase
   end

   // result transaction built in the current state
   always_comb begin
      out_in = blank;
      out_set = 1'b0;
      case (state_ff)
         ST_EXEC: begin
            out_in.kind = KIND_REGRD;
            out_in.last = 1'b1;
            case (sel_ff)
               SEL_CTRL: out_in.read_data = {13'd0, status_ff};
               SEL_ADDRH: out_in.read_data = {8'd0, addr_ff[23:16]};
               SEL_ADDRM: out_in.read_data = {8'd0, addr_ff[15:8]};
               SEL_ADDRL: out_in.read_data = {8'd0, addr_ff[7:0]};
               default: out_in.read_data = '0;
            endcase
            out_set = (mode_ff == MODE_READ);
         end
         ST_DEV: begin
            out_in.kind = KIND_DEV;
            out_in.device_data = ram_rd;
            out_in.last = (bcnt_ff == '0);
            out_set = out_free;
         end
         ST_BURST: begin
            out_in.mem_address = addr_ff;
            out_in.last = (bcnt_ff == PendW'(1));
            if (bwrite_ff) begin
               out_in.kind = KIND_MEMWR;
               out_in.mem_data = ram_rd;
            end else out_in.kind = KIND_MEMRD;
            out_set = out_free && !(bwrite_ff && !bfirst_ff);
         end
         default: ;
      endcase
   end

   // output register: load a new transaction, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (out_set) out_v_ff <= 1'b1;
      else if (rsp_tready) out_v_ff <= 1'b0;
      if (out_set) out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ctrl_ff <= '0;
         status_ff <= 3'd1;
         addr_ff <= '0;
         sect_ff <= '0;
         bis_ff <= '0;
         act_ff <= 1'b0;
         fill_ff[0] <= '0; fill_ff[1] <= '0;
         ridx_ff[0] <= '0; ridx_ff[1] <= '0;
         slot_ff <= '0;
         pend_ff <= '0;
         bcnt_ff <= '0;
         bfirst_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid && req_tready) begin
                  mode_ff <= req_tdata[2:0];
                  sel_ff <= req_tdata[5:3];
                  wd_ff <= req_tdata[21:6];
                  dbyte_ff <= req_tdata[29:22];
                  mbyte_ff <= req_tdata[37:30];
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               state_ff <= state_in;
               case (mode_ff)
                  MODE_WRITE: begin
                     case (sel_ff)
                        SEL_CTRL: begin
                           if (|((ctrl_ff ^ wd_ff) & CTRL_DIR)) begin
                              status_ff <= 3'd1;
                              sect_ff <= '0;
                              bis_ff <= '0;
                              act_ff <= 1'b0;
                              fill_ff[0] <= '0; fill_ff[1] <= '0;
                              ridx_ff[0] <= '0; ridx_ff[1] <= '0;
                              slot_ff <= '0;
                              pend_ff <= '0;
                           end
                           ctrl_ff <= wd_ff;
                        end
                        SEL_SECT: begin
                           if (|(ctrl_ff & CTRL_SECT)) begin
                              sect_ff <= wd_ff;
                              if (wd_ff != 16'd0) status_ff <= status_ff | 3'd2;
                              if (dir) begin
                                 fill_ff[0] <= FillW'(BufferBytes);
                                 fill_ff[1] <= FillW'(BufferBytes);
                                 ridx_ff[0] <= '0; ridx_ff[1] <= '0;
                                 slot_ff <= '0;
                                 pend_ff <= PendW'(StoreSize);
                                 bcnt_ff <= PendW'(StoreSize);
                                 bwrite_ff <= 1'b0;
                              end
                           end
                        end
                        SEL_ADDRH: addr_ff[23:16] <= wd_ff[7:0];
                        SEL_ADDRM: addr_ff[15:8] <= wd_ff[7:0];
                        SEL_ADDRL: addr_ff[7:0] <= wd_ff[7:0];
                        default: ;
                     endcase
                  end
                  MODE_DEVREQ: begin
                     if (sect_ff == 16'd0) status_ff <= status_ff | 3'd4;
                     else begin
                        if (sect_end) status_ff <= (status_ff | 3'd4) & ~3'd2;
                        else status_ff <= status_ff | 3'd4;
                        bis_ff <= bis_step;
                        sect_ff <= sect_step;
                        if (dir) begin
                           // RAM read of the device byte issued this cycle
                           if (!sect_end && ridx_ff[act_ff] + FillW'(1)
                               >= FillW'(BufferBytes)) begin
                              ridx_ff[act_ff] <= '0;
                              if (pend_ff == '0) slot_ff <= {act_ff, IdxW'(0)};
                              if (pend_ff + PendW'(BufferBytes) > PendW'(StoreSize))
                                 pend_ff <= PendW'(StoreSize);
                              else pend_ff <= pend_ff + PendW'(BufferBytes);
                              fill_ff[act_ff] <= FillW'(BufferBytes);
                              act_ff <= ~act_ff;
                              bcnt_ff <= PendW'(BufferBytes);
                           end else begin
                              ridx_ff[act_ff] <= ridx_ff[act_ff] + FillW'(1);
                              bcnt_ff <= '0;
                           end
                           bwrite_ff <= 1'b0;
                           bfirst_ff <= 1'b0;
                        end else begin
                           fill_ff[act_ff] <= FillW'(wpos) + FillW'(1);
                           if (FillW'(wpos) + FillW'(1) >= FillW'(BufferBytes)) begin
                              act_ff <= ~act_ff;
                              ridx_ff[~act_ff] <= '0;
                              fill_ff[~act_ff] <= '0;
                              bcnt_ff <= PendW'(BufferBytes);
                              bwrite_ff <= 1'b1;
                              bbase_ff <= act_ff;
                              bpos_ff <= '0;
                              bfirst_ff <= 1'b0;
                           end
                        end
                     end
                  end
                  MODE_RELEASE: status_ff <= status_ff & ~3'd4;
                  MODE_REPLY: begin
                     if (pend_ff != '0) begin
                        slot_ff <= slot_ff + SlotW'(1);
                        pend_ff <= pend_ff - PendW'(1);
                     end
                  end
                  default: ;
               endcase
            end
            ST_DEV: begin
               // RAM data for the device byte is valid now
               if (out_free) state_ff <= (bcnt_ff == '0) ? ST_IDLE : ST_BURST;
            end
            ST_BURST: begin
               if (bwrite_ff && !bfirst_ff) begin
                  // prime the RAM read of the first byte
                  bfirst_ff <= 1'b1;
                  bpos_ff <= bpos_ff + IdxW'(1);
               end else if (out_free) begin
                  if (bwrite_ff) bpos_ff <= bpos_ff + IdxW'(1);
                  addr_ff <= addr_ff + 24'd1;
                  bcnt_ff <= bcnt_ff - PendW'(1);
                  if (bcnt_ff == PendW'(1)) state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

[bench/disk_dma_double_fifo_controller_tb.sv]
// Self-checking testbench for the disk DMA double buffer controller.
module disk_dma_double_fifo_controller_tb;
   import ddfc_pkg::*;

   typedef struct packed {
      logic [7:0] memory_byte;
      logic [7:0] device_byte;
      logic [15:0] write_data;
      logic [2:0] reg_select;
      logic [2:0] mode;
   } dma_cmd_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [39:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast;

   disk_dma_double_fifo_controller dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always #2 clock = ~clock;

   // Commands waiting for the driver and bus results still owed by the block.
   dma_cmd_t cmd_q[$];
   rsp_type bus_q[$];
   int errors = 0;
   int cmd_count = 0;

   // Shadow copy of the controller state.
   logic [15:0] ctl;
   logic [2:0] stat;
   logic [23:0] addr;
   int sect, bis, act, slot, pend_cnt;
   int fill[2];
   int ridx[2];
   logic [7:0] store[StoreSize];
   bit written[StoreSize];

   task automatic emit(logic [1:0] kind, logic [15:0] rd, logic [23:0] ad,
                       logic [7:0] md, logic [7:0] dd);
      rsp_type r;
      r.kind = kind;
      r.read_data = rd;
      r.mem_address = ad;
      r.mem_data = md;
      r.device_data = dd;
      r.to_floppy = ctl[7];
      r.last = 1'b0;
      bus_q.push_back(r);
   endtask

   task automatic fetch_burst(int count);
      for (int i = 0; i < count; i++) begin
         emit(KIND_MEMRD, '0, addr, '0, '0);
         addr = addr + 24'd1;
      end
   endtask

   // Advance the sector byte counter; return 1 when the last sector ends.
   function automatic bit tick_byte();
      bis++;
      if (bis >= SectorBytes) begin
         bis = 0;
         sect = (sect - 1) & 16'hFFFF;
         if (sect == 0) begin
            stat[1] = 1'b0;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   task automatic predict_dma(dma_cmd_t c);
      int base, pos, start;
      logic [15:0] v;
      base = act * BufferBytes;
      start = bus_q.size();
      case (c.mode)
         MODE_WRITE: begin
            if (c.reg_select == SEL_CTRL) begin
               if ((ctl ^ c.write_data) & CTRL_DIR) begin
                  stat = 3'd1; sect = 0; bis = 0; act = 0;
                  fill[0] = 0; fill[1] = 0; ridx[0] = 0; ridx[1] = 0;
                  slot = 0; pend_cnt = 0;
               end
               ctl = c.write_data;
            end else if (c.reg_select == SEL_SECT) begin
               if (ctl & CTRL_SECT) begin
                  sect = c.write_data;
                  if (sect > 0) stat[1] = 1'b1;
                  if (ctl & CTRL_DIR) begin
                     fill[0] = BufferBytes; fill[1] = BufferBytes;
                     ridx[0] = 0; ridx[1] = 0; slot = 0; pend_cnt = StoreSize;
                     fetch_burst(StoreSize);
                  end
               end
            end else if (c.reg_select == SEL_ADDRH) addr[23:16] = c.write_data[7:0];
            else if (c.reg_select == SEL_ADDRM) addr[15:8] = c.write_data[7:0];
            else if (c.reg_select == SEL_ADDRL) addr[7:0] = c.write_data[7:0];
         end
         MODE_READ: begin
            v = '0;
            if (c.reg_select == SEL_CTRL) v = {13'd0, stat};
            else if (c.reg_select == SEL_ADDRH) v = {8'd0, addr[23:16]};
            else if (c.reg_select == SEL_ADDRM) v = {8'd0, addr[15:8]};
            else if (c.reg_select == SEL_ADDRL) v = {8'd0, addr[7:0]};
            emit(KIND_REGRD, v, '0, '0, '0);
         end
         MODE_DEVREQ: begin
            stat[2] = 1'b1;
            if (sect != 0) begin
               if (ctl & CTRL_DIR) begin
                  pos = ridx[act] % BufferBytes;
                  emit(KIND_DEV, '0, '0, '0, store[base + pos]);
                  ridx[act]++;
                  if (!tick_byte() && ridx[act] >= BufferBytes) begin
                     if (pend_cnt == 0) slot = base;
                     pend_cnt = pend_cnt + BufferBytes;
                     if (pend_cnt > StoreSize) pend_cnt = StoreSize;
                     ridx[act] = 0;
                     fill[act] = BufferBytes;
                     fetch_burst(BufferBytes);
                     act ^= 1;
                  end
               end else begin
                  pos = fill[act] % BufferBytes;
                  store[base + pos] = c.device_byte;
                  written[base + pos] = 1'b1;
                  fill[act] = pos + 1;
                  if (fill[act] >= BufferBytes) begin
                     for (int i = 0; i < BufferBytes; i++) begin
                        emit(KIND_MEMWR, '0, addr, store[base + i], '0);
                        addr = addr + 24'd1;
                     end
                     act ^= 1;
                     ridx[act] = 0;
                     fill[act] = 0;
                  end
                  void'(tick_byte());
               end
            end
         end
         MODE_RELEASE: stat[2] = 1'b0;
         MODE_REPLY: begin
            if (pend_cnt > 0) begin
               store[slot % StoreSize] = c.memory_byte;
               written[slot % StoreSize] = 1'b1;
               slot = (slot + 1) % StoreSize;
               pend_cnt--;
            end
         end
         default: ;
      endcase
      if (bus_q.size() > start) begin
         rsp_type r;
         r = bus_q.pop_back();
         r.last = 1'b1;
         bus_q.push_back(r);
      end
   endtask

   // Queue one command; a device request that would read a buffer byte not yet
   // delivered by memory turns into a memory reply (or a release).
   task automatic send(logic [2:0] mode, logic [2:0] sel, logic [15:0] wd,
                       logic [7:0] db, logic [7:0] mb);
      dma_cmd_t c;
      if (mode == MODE_DEVREQ && sect != 0 && (ctl & CTRL_DIR) &&
          !written[act * BufferBytes + ridx[act] % BufferBytes])
         mode = (pend_cnt > 0) ? MODE_REPLY : MODE_RELEASE;
      c.mode = mode; c.reg_select = sel; c.write_data = wd;
      c.device_byte = db; c.memory_byte = mb;
      predict_dma(c);
      cmd_q.push_back(c);
      cmd_count++;
   endtask

   task automatic send_rand_devreq();
      send(MODE_DEVREQ, 3'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic setup_transfer(bit dir, int sectors);
      logic [15:0] cw;
      cw = 16'($urandom) & ~CTRL_DIR | CTRL_SECT;
      if (dir) cw = cw | CTRL_DIR;
      send(MODE_WRITE, SEL_CTRL, cw, '0, '0);
      send(MODE_WRITE, SEL_ADDRH, 16'($urandom), '0, '0);
      send(MODE_WRITE, SEL_ADDRM, 16'($urandom), '0, '0);
      send(MODE_WRITE, SEL_ADDRL, 16'($urandom), '0, '0);
      send(MODE_WRITE, SEL_SECT, 16'(sectors), '0, '0);
   endtask

   // Fill the command queue and wait for the run to drain.
   initial begin
      int kind;
      ctl = '0; stat = 3'd1; addr = '0; sect = 0; bis = 0; act = 0;
      slot = 0; pend_cnt = 0; fill[0] = 0; fill[1] = 0; ridx[0] = 0; ridx[1] = 0;
      for (int i = 0; i < StoreSize; i++) begin
         store[i] = '0;
         written[i] = 1'b0;
      end
      // Directed: reset values, every selector, idle request, stray reply.
      for (int s = 0; s < 8; s++) send(MODE_READ, 3'(s), '0, '0, '0);
      send(MODE_DEVREQ, SEL_CTRL, '0, 8'hFF, '0);
      send(MODE_REPLY, SEL_CTRL, '0, '0, 8'hFF);
      send(MODE_WRITE, SEL_SECT, 16'hFFFF, '0, '0);
      send(MODE_WRITE, SEL_ADDRH, 16'hFFFF, '0, '0);
      send(MODE_WRITE, SEL_ADDRM, 16'hFF00, '0, '0);
      send(MODE_WRITE, SEL_ADDRL, 16'h00FF, '0, '0);
      send(MODE_WRITE, 3'd7, 16'hFFFF, '0, '0);
      for (int s = 2; s < 5; s++) send(MODE_READ, 3'(s), '0, '0, '0);
      send(MODE_WRITE, SEL_CTRL, CTRL_FLOPPY | CTRL_SECT, '0, '0);
      send(MODE_READ, SEL_CTRL, '0, '0, '0);
      send(3'd5, 3'd7, 16'hFFFF, 8'hFF, 8'hFF);
      send(3'd7, 3'd5, 16'hFFFF, 8'hFF, 8'hFF);
      send(MODE_RELEASE, SEL_CTRL, '0, '0, '0);
      send(MODE_READ, SEL_CTRL, '0, '0, '0);
      // Random phase: mostly well-formed transfers, some noise.
      while (cmd_count < 220) begin
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            setup_transfer(1'b0, $urandom_range(1, 3));
            repeat ($urandom_range(16, 40)) begin
               if ($urandom_range(0, 7) == 0) send(MODE_RELEASE, '0, '0, '0, '0);
               else if ($urandom_range(0, 7) == 0) send(MODE_READ, '0, '0, '0, '0);
               else send_rand_devreq();
            end
         end else if (kind < 8) begin
            setup_transfer(1'b1, $urandom_range(1, 2));
            repeat ($urandom_range(40, 70)) begin
               if (pend_cnt > 0 && $urandom_range(0, 2) != 0)
                  send(MODE_REPLY, 3'($urandom), 16'($urandom), '0, 8'($urandom));
               else send_rand_devreq();
            end
         end else begin
            repeat ($urandom_range(3, 10))
               send(3'($urandom), 3'($urandom), 16'($urandom), 8'($urandom),
                    8'($urandom));
         end
      end
      wait (!reset);
      wait (cmd_q.size() == 0);
      wait (bus_q.size() == 0);
      repeat (40) @(posedge clock);
      if (errors == 0) $display("disk_dma_double_fifo_controller: match");
      else $display("disk_dma_double_fifo_controller: mismatch");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      #8000000;
      $display("disk_dma_double_fifo_controller: mismatch");
      $finish;
   end

   // Driver: offer commands in bursts, hold each until the block accepts it.
   logic req_fire = 1'b0;
   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) req_fire <= req_tvalid && req_tready;

   always @(negedge clock) begin
      logic nv;
      nv = req_tvalid;
      if (reset) begin
         nv = 1'b0;
      end else begin
         if (req_fire) begin
            void'(cmd_q.pop_front());
            nv = 1'b0;
         end
         if (!nv) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (cmd_q.size() > 0) begin
               nv = 1'b1;
               req_tdata <= {2'b00, cmd_q[0]};
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 20);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
      req_tvalid <= nv;
   end

   // Receiver: stall on its own pattern, with one long hold-off to back up the block.
   int rx_cycle = 0;
   int hold_left = 0;

   always @(negedge clock) begin
      rx_cycle++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (rx_cycle == 300) begin
         hold_left = 200;
         rsp_tready <= 1'b0;
      end else begin
         case ((rx_cycle / 64) % 3)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   // Monitor: compare each result transaction with the oldest owed result.
   always @(posedge clock) begin
      rsp_type e;
      logic [63:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (bus_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: user %0d data %h last %b",
                        rsp_tuser, rsp_tdata, rsp_tlast);
         end else begin
            e = bus_q.pop_front();
            want = {7'b0, e.to_floppy, e.device_data, e.mem_data, e.mem_address,
                    e.read_data};
            if (rsp_tdata !== want || rsp_tuser !== e.kind || rsp_tlast !== e.last) begin
               errors++;
               if (errors <= 10)
                  $display("result differs: want user %0d data %h last %b, got %0d %h %b",
                           e.kind, want, e.last, rsp_tuser, rsp_tdata, rsp_tlast);
            end
         end
      end
   end
endmodule
